FILE: design/dopq_pkg.sv
// Shared types and constants for the dual-order priority queue.
package dopq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ID_W         = 16;
	localparam int AGE_W        = 8;
	localparam int CNT_OUT_W    = 5;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_POP_HI  = 2'd1,
		OP_POP_ARR = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	// one stored entry as it moves along the row
	typedef struct packed {
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [AGE_W-1:0] age;
	} entry_t;

	// broadcast to every cell; the search keys travel on ports of their own
	typedef struct packed {
		logic ins;
		logic pop_hi;
		logic pop_arr;
	} cmd_t;

endpackage

FILE: design/dopq_cell.sv
// One cell of the priority-sorted row: holds an entry and its arrival rank.
module dopq_cell #(
	parameter int RANK_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dopq_pkg::cmd_t             cmd,
	input  logic [dopq_pkg::ID_W-1:0]  key_id,
	input  logic [dopq_pkg::AGE_W-1:0] key_age,
	input  logic [RANK_W-1:0]          new_rank,
	input  logic [RANK_W-1:0]          rem_rank,
	input  dopq_pkg::entry_t           left_ent,
	input  logic [RANK_W-1:0]          left_rank,
	input  dopq_pkg::entry_t           right_ent,
	input  logic [RANK_W-1:0]          right_rank,
	input  logic                       ga_left,
	input  logic                       past_left,
	output dopq_pkg::entry_t           ent,
	output logic [RANK_W-1:0]          rank,
	output logic                       ga,
	output logic                       past,
	output logic                       id_hit,
	output logic                       rank0_hit
);

	logic                     valid_q;
	logic [dopq_pkg::ID_W-1:0]  id_q;
	logic [dopq_pkg::AGE_W-1:0] age_q;
	logic [RANK_W-1:0]        rank_q;

	dopq_pkg::entry_t  nxt_ent;
	logic [RANK_W-1:0] nxt_rank;
	logic [RANK_W-1:0] right_rank_dec;
	logic [RANK_W-1:0] own_rank_dec;

	assign ent  = '{valid: valid_q, id: id_q, age: age_q};
	assign rank = rank_q;

	// sorted row: cells that stay ahead of a new entry form a prefix
	assign ga        = valid_q && (age_q >= key_age);
	assign rank0_hit = valid_q && (rank_q == '0);
	assign past      = past_left | rank0_hit;
	assign id_hit    = valid_q && (id_q == key_id);

	assign right_rank_dec = (right_rank > rem_rank) ? right_rank - 1'b1 : right_rank;
	assign own_rank_dec   = (rank_q > rem_rank) ? rank_q - 1'b1 : rank_q;

	always_comb begin
		nxt_ent  = ent;
		nxt_rank = rank_q;
		if (cmd.ins) begin
			if (!ga) begin
				if (ga_left) begin
					nxt_ent  = '{valid: 1'b1, id: key_id, age: key_age};
					nxt_rank = new_rank;
				end else begin
					nxt_ent  = left_ent;
					nxt_rank = left_rank;
				end
			end
		end else if (cmd.pop_hi) begin
			nxt_ent  = right_ent;
			nxt_rank = right_rank_dec;
		end else if (cmd.pop_arr) begin
			if (past) begin
				nxt_ent  = right_ent;
				nxt_rank = right_rank_dec;
			end else begin
				nxt_rank = own_rank_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= nxt_ent.id;
		age_q  <= nxt_ent.age;
		rank_q <= nxt_rank;
	end

endmodule

FILE: design/dual_order_priority_queue.sv
// Top level: dual-order priority queue built from a row of sorted cells.
//
//  channel   | handshake         | fields
//  ----------+-------------------+-----------------------------
//  command   | start / busy      | op, id, age
//  result    | done (strobe)     | ok, out_id, out_age, count
//
// One command per cycle: its result is on the result ports, with done high
// for a single cycle, the cycle after the transfer. The row settles each
// operation as it is taken, so busy stays low. Reset empties the row
// at once; no sweep. The receiver cannot stall; results are never held.
module dual_order_priority_queue #(
	parameter int CAPACITY = dopq_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic [dopq_pkg::ID_W-1:0]     id,
	input  logic [dopq_pkg::AGE_W-1:0]    age,
	output logic                          done,
	output logic                          ok,
	output logic [dopq_pkg::ID_W-1:0]     out_id,
	output logic [dopq_pkg::AGE_W-1:0]    out_age,
	output logic [dopq_pkg::CNT_OUT_W-1:0] count
);

	localparam int RANK_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	dopq_pkg::entry_t  ents    [CAPACITY];
	logic [RANK_W-1:0] ranks   [CAPACITY];
	logic              gas     [CAPACITY];
	logic              pasts   [CAPACITY];
	logic [CAPACITY-1:0] id_hits;
	logic [CAPACITY-1:0] r0_hits;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	dopq_pkg::cmd_t   cmd;
	dopq_pkg::op_t    op_e;
	logic             xfer;
	logic             dup;
	logic             full;
	logic             empty;
	logic [RANK_W-1:0] new_rank;
	logic [RANK_W-1:0] rem_rank;

	logic                       res_ok;
	logic [dopq_pkg::ID_W-1:0]  res_id;
	logic [dopq_pkg::AGE_W-1:0] res_age;
	logic [dopq_pkg::ID_W-1:0]  arr_id;
	logic [dopq_pkg::AGE_W-1:0] arr_age;
	logic [dopq_pkg::AGE_W-1:0] qry_age;

	logic                          done_q;
	logic                          ok_q;
	logic [dopq_pkg::ID_W-1:0]     out_id_q;
	logic [dopq_pkg::AGE_W-1:0]    out_age_q;
	logic [dopq_pkg::CNT_OUT_W-1:0] count_res_q;

	assign busy  = 1'b0;
	assign xfer  = start && !busy;
	assign op_e  = dopq_pkg::op_t'(op);
	assign dup   = |id_hits;
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign new_rank = count_q[RANK_W-1:0];

	always_comb begin
		cmd      = '0;
		rem_rank = '0;
		unique case (op_e)
			dopq_pkg::OP_INSERT:  cmd.ins     = xfer && !dup && !full;
			dopq_pkg::OP_POP_HI: begin
				cmd.pop_hi = xfer && !empty;
				rem_rank   = ranks[0];
			end
			dopq_pkg::OP_POP_ARR: cmd.pop_arr = xfer && !empty;
			dopq_pkg::OP_QUERY:   ;
			default:              ;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			dopq_pkg::entry_t  l_ent;
			logic [RANK_W-1:0] l_rank;
			dopq_pkg::entry_t  r_ent;
			logic [RANK_W-1:0] r_rank;
			logic              l_ga;
			logic              l_past;

			if (g == 0) begin : g_head
				assign l_ent  = '0;
				assign l_rank = '0;
				assign l_ga   = 1'b1;
				assign l_past = 1'b0;
			end else begin : g_body
				assign l_ent  = ents[g-1];
				assign l_rank = ranks[g-1];
				assign l_ga   = gas[g-1];
				assign l_past = pasts[g-1];
			end

			if (g == CAPACITY - 1) begin : g_tail
				assign r_ent  = '0;
				assign r_rank = '0;
			end else begin : g_mid
				assign r_ent  = ents[g+1];
				assign r_rank = ranks[g+1];
			end

			dopq_cell #(.RANK_W(RANK_W)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.key_id     (id),
				.key_age    (age),
				.new_rank   (new_rank),
				.rem_rank   (rem_rank),
				.left_ent   (l_ent),
				.left_rank  (l_rank),
				.right_ent  (r_ent),
				.right_rank (r_rank),
				.ga_left    (l_ga),
				.past_left  (l_past),
				.ent        (ents[g]),
				.rank       (ranks[g]),
				.ga         (gas[g]),
				.past       (pasts[g]),
				.id_hit     (id_hits[g]),
				.rank0_hit  (r0_hits[g])
			);
		end
	endgenerate

	// one-hot selects: the oldest arrival and the queried id
	always_comb begin
		arr_id  = '0;
		arr_age = '0;
		qry_age = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			arr_id  = arr_id  | ({dopq_pkg::ID_W{r0_hits[i]}} & ents[i].id);
			arr_age = arr_age | ({dopq_pkg::AGE_W{r0_hits[i]}} & ents[i].age);
			qry_age = qry_age | ({dopq_pkg::AGE_W{id_hits[i]}} & ents[i].age);
		end
	end

	always_comb begin
		res_ok    = 1'b0;
		res_id    = '0;
		res_age   = '0;
		count_nxt = count_q;
		unique case (op_e)
			dopq_pkg::OP_INSERT: begin
				res_ok = cmd.ins;
				if (cmd.ins) begin
					count_nxt = count_q + 1'b1;
				end
			end
			dopq_pkg::OP_POP_HI: begin
				res_ok = !empty;
				if (!empty) begin
					res_id    = ents[0].id;
					res_age   = ents[0].age;
					count_nxt = count_q - 1'b1;
				end
			end
			dopq_pkg::OP_POP_ARR: begin
				res_ok = !empty;
				if (!empty) begin
					res_id    = arr_id;
					res_age   = arr_age;
					count_nxt = count_q - 1'b1;
				end
			end
			dopq_pkg::OP_QUERY: begin
				res_ok  = dup;
				res_age = qry_age;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= xfer;
			if (xfer) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			ok_q        <= res_ok;
			out_id_q    <= res_id;
			out_age_q   <= res_age;
			count_res_q <= dopq_pkg::CNT_OUT_W'(count_nxt);
		end
	end

	assign done    = done_q;
	assign ok      = ok_q;
	assign out_id  = out_id_q;
	assign out_age = out_age_q;
	assign count   = count_res_q;

endmodule
